[hw/rtl/assert_macros.svh]
// assertion macros shared by the rtl files that check their own logic
// no dependencies; every macro is clocked and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define BCC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define BCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// invariant that holds at every clock edge out of reset
`define BCC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

[hw/rtl/bcc_pkg.sv]
// shared types, constants and fixed-point helpers of the balance cascade controller
// no dependencies; used by the interfaces and by every rtl module
package bcc_pkg;

   // field and datapath widths
   localparam int GAIN_FRAC_BITS_DEF = 16;
   localparam int GAIN_W   = 32;
   localparam int IN_W     = 16;
   localparam int LIMIT_W  = 16;
   localparam int DRIVE_W  = 17;
   localparam int IDX_W    = 8;
   localparam int TARGET_W = 7;
   localparam int ERR_W    = 18;
   localparam int INTEG_W  = 15;
   localparam int MUL_W    = 33;
   localparam int ACC_W    = 66;

   // control constants
   localparam int SPEED_LIMIT    = 30;
   localparam int TURN_LIMIT     = 35;
   localparam int TURN_STEP      = 7;
   localparam int INTEGRAL_LIMIT = 10000;
   localparam int FALL_LIMIT_Q8  = 40 * 256;

   // register indexes
   typedef enum logic [IDX_W-1:0] {
      CSR_UPRIGHT_KP    = 8'd0,
      CSR_UPRIGHT_KD    = 8'd1,
      CSR_SPEED_KP      = 8'd2,
      CSR_SPEED_KI      = 8'd3,
      CSR_STEER_KP      = 8'd4,
      CSR_STEER_KD      = 8'd5,
      CSR_BALANCE_ANGLE = 8'd6,
      CSR_PWM_LIMIT     = 8'd7
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]         upright_kp;
      logic [GAIN_W-1:0]         upright_kd;
      logic [GAIN_W-1:0]         speed_kp;
      logic [GAIN_W-1:0]         speed_ki;
      logic [GAIN_W-1:0]         steer_kp;
      logic [GAIN_W-1:0]         steer_kd;
      logic signed [IN_W-1:0]    balance_angle;
      logic [LIMIT_W-1:0]        pwm_limit;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      upright_kp:    32'd26214400,
      upright_kd:    32'd81920,
      speed_kp:      32'd22938,
      speed_ki:      32'd115,
      steer_kp:      32'd2621440,
      steer_kd:      32'd72090,
      balance_angle: 16'sd128,
      pwm_limit:     16'd7200
   };

   // control of the shared multiply-accumulate unit
   typedef struct packed {
      logic                    acc_load;
      logic                    acc_add;
      logic signed [ACC_W-1:0] load_val;
   } mac_ctl_type;

   // arithmetic shift right that rounds toward zero
   function automatic logic signed [ACC_W-1:0] trunc_shift(
      input logic signed [ACC_W-1:0] v,
      input int unsigned             sh);
      logic [ACC_W-1:0] bias;
      bias = v[ACC_W-1] ? ((ACC_W'(1) << sh) - ACC_W'(1)) : '0;
      return (v + $signed(bias)) >>> sh;
   endfunction

   // saturate to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      logic in_range;
      in_range = (v[ACC_W-1:31] == '0) || (v[ACC_W-1:31] == '1);
      if (in_range) begin
         return v[31:0];
      end else if (v[ACC_W-1]) begin
         return 32'sh8000_0000;
      end else begin
         return 32'sh7fff_ffff;
      end
   endfunction

endpackage

[hw/rtl/bcc_if.sv]
// valid/ready channel interfaces: control tick in, motor drives out, register writes
// depends on bcc_pkg for field widths
interface bcc_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [bcc_pkg::IN_W-1:0]     enc_left;
   logic signed [bcc_pkg::IN_W-1:0]     enc_right;
   logic signed [bcc_pkg::IN_W-1:0]     pitch;
   logic signed [bcc_pkg::IN_W-1:0]     rate_y;
   logic signed [bcc_pkg::IN_W-1:0]     rate_z;
   logic                                go_fore;
   logic                                go_back;
   logic                                go_left;
   logic                                go_right;

   modport source (output valid, enc_left, enc_right, pitch, rate_y, rate_z,
                   go_fore, go_back, go_left, go_right, input ready);
   modport sink   (input valid, enc_left, enc_right, pitch, rate_y, rate_z,
                   go_fore, go_back, go_left, go_right, output ready);
endinterface

interface bcc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [bcc_pkg::DRIVE_W-1:0]  drive_left;
   logic signed [bcc_pkg::DRIVE_W-1:0]  drive_right;
   logic                                fallen;

   modport source (output valid, drive_left, drive_right, fallen, input ready);
   modport sink   (input valid, drive_left, drive_right, fallen, output ready);
endinterface

interface bcc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [bcc_pkg::IDX_W-1:0]           index;
   logic [bcc_pkg::GAIN_W-1:0]          data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/balance_cascade_controller_unit.sv]
// Balance cascade controller: one result per accepted control tick.
// Ticks run through the filter, upright, speed, steer, mix and PWM states to ST_OUT,
// which loads the output register once it is free; nine products share one 33x33
// multiply-accumulate unit, input ready only in idle, output register decouples.
// Reset (synchronous, active high): registers to defaults, targets, filter,
// integral and pending clear to zero; no clearing pass.
`include "assert_macros.svh"

module balance_cascade_controller_unit #(
   parameter int GAIN_FRAC_BITS = bcc_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   bcc_req_if.sink    req_ch,
   bcc_rsp_if.source  rsp_ch,
   bcc_csr_if.sink    csr_ch
);

   localparam int IN_W      = bcc_pkg::IN_W;
   localparam int GAIN_W    = bcc_pkg::GAIN_W;
   localparam int LIMIT_W   = bcc_pkg::LIMIT_W;
   localparam int DRIVE_W   = bcc_pkg::DRIVE_W;
   localparam int TARGET_W  = bcc_pkg::TARGET_W;
   localparam int ERR_W     = bcc_pkg::ERR_W;
   localparam int INTEG_W   = bcc_pkg::INTEG_W;
   localparam int MUL_W     = bcc_pkg::MUL_W;
   localparam int ACC_W     = bcc_pkg::ACC_W;
   localparam int TGT_EXT_W = TARGET_W + 1;
   localparam int DIFF_W    = IN_W + 1;
   localparam int ISUM_W    = ERR_W + 1;
   localparam int TURN_W    = 50 - GAIN_FRAC_BITS;
   localparam int MIX_W     = ((TURN_W > 32) ? TURN_W : 32) + 1;

   // filter weights: round(0.7 * one) and its complement
   localparam longint ONE_Q      = longint'(1) << GAIN_FRAC_BITS;
   localparam logic [MUL_W-1:0] FILTER_NEW = MUL_W'((7 * ONE_Q + 5) / 10);
   localparam logic [MUL_W-1:0] FILTER_OLD = MUL_W'(ONE_Q) - FILTER_NEW;

   localparam logic signed [TGT_EXT_W-1:0] TGT_ONE  = TGT_EXT_W'(1);
   localparam logic signed [TGT_EXT_W-1:0] TGT_STEP = TGT_EXT_W'(bcc_pkg::TURN_STEP);
   localparam logic signed [TGT_EXT_W-1:0] SPD_MAX  = TGT_EXT_W'(bcc_pkg::SPEED_LIMIT);
   localparam logic signed [TGT_EXT_W-1:0] TRN_MAX  = TGT_EXT_W'(bcc_pkg::TURN_LIMIT);
   localparam logic signed [ISUM_W-1:0]    INT_MAX  = ISUM_W'(bcc_pkg::INTEGRAL_LIMIT);
   localparam logic signed [IN_W-1:0]      FALL_MAX = IN_W'(bcc_pkg::FALL_LIMIT_Q8);

   typedef enum logic [12:0] {
      ST_IDLE     = 13'b0000000000001,
      ST_FILT_NEW = 13'b0000000000010,
      ST_FILT_OLD = 13'b0000000000100,
      ST_UP_ANGLE = 13'b0000000001000,
      ST_UP_RATE  = 13'b0000000010000,
      ST_SPD_P    = 13'b0000000100000,
      ST_SPD_I    = 13'b0000001000000,
      ST_STR_D    = 13'b0000010000000,
      ST_STR_P    = 13'b0000100000000,
      ST_MIX_VEL  = 13'b0001000000000,
      ST_MIX_VERT = 13'b0010000000000,
      ST_PWM      = 13'b0100000000000,
      ST_OUT      = 13'b1000000000000
   } state_type;

   // clamp of a mixed drive to the symmetric limit
   function automatic logic signed [DRIVE_W-1:0] clamp_drive(
      input logic signed [MIX_W-1:0] v,
      input logic signed [MIX_W-1:0] lim);
      logic signed [MIX_W-1:0] r;
      if (v > lim) begin
         r = lim;
      end else if (v < -lim) begin
         r = -lim;
      end else begin
         r = v;
      end
      return r[DRIVE_W-1:0];
   endfunction

   bcc_pkg::cfg_type     cfg;
   bcc_pkg::mac_ctl_type mac_ctl;
   logic signed [MUL_W-1:0] op_a;
   logic signed [MUL_W-1:0] op_b;
   logic signed [ACC_W-1:0] acc;

   state_type state_ff, state_in;

   // loop state
   logic signed [TARGET_W-1:0] st_ff, st_in;
   logic signed [TARGET_W-1:0] tt_ff, tt_in;
   logic signed [ERR_W-1:0]    fe_ff, fe_in;
   logic signed [INTEG_W-1:0]  integ_ff, integ_in;
   logic                       pend_ff, pend_in;

   // per-tick working registers
   logic signed [ERR_W-1:0]    err_ff, err_in;
   logic signed [DIFF_W-1:0]   diff_ff, diff_in;
   logic signed [IN_W-1:0]     gy_ff, gy_in;
   logic signed [IN_W-1:0]     gz_ff, gz_in;
   logic [GAIN_W-1:0]          kd_ff, kd_in;
   logic                       fall_ff, fall_in;
   logic signed [31:0]         vert_ff, vert_in;
   logic signed [31:0]         vel_ff, vel_in;
   logic signed [TURN_W-1:0]   turn_ff, turn_in;
   logic signed [31:0]         pwm_ff, pwm_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [DRIVE_W-1:0]  drive_l_ff, drive_l_in;
   logic signed [DRIVE_W-1:0]  drive_r_ff, drive_r_in;
   logic                       fallen_ff, fallen_in;

   logic                       req_take;
   logic                       out_free;
   logic signed [TGT_EXT_W-1:0] spd_sum, trn_sum;
   logic signed [ACC_W-1:0]    shift_f;
   logic signed [ACC_W-1:0]    shift_f8;
   logic signed [ERR_W-1:0]    low;
   logic signed [ISUM_W-1:0]   isum;
   logic signed [MIX_W-1:0]    lim_m;
   logic signed [MIX_W-1:0]    mix_l, mix_r;
   logic signed [DRIVE_W-1:0]  lim_d;

   bcc_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   bcc_mac u_mac (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .ctl   (mac_ctl),
      .acc   (acc)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.drive_left  = drive_l_ff;
   assign rsp_ch.drive_right = drive_r_ff;
   assign rsp_ch.fallen      = fallen_ff;

   // target ramps from the command bits
   always_comb begin
      spd_sum = (req_ch.go_fore || req_ch.go_back) ? TGT_EXT_W'(st_ff) : '0;
      if (req_ch.go_fore) spd_sum = spd_sum + TGT_ONE;
      if (req_ch.go_back) spd_sum = spd_sum - TGT_ONE;
      if (spd_sum > SPD_MAX) begin
         spd_sum = SPD_MAX;
      end else if (spd_sum < -SPD_MAX) begin
         spd_sum = -SPD_MAX;
      end

      trn_sum = (req_ch.go_left || req_ch.go_right) ? TGT_EXT_W'(tt_ff) : '0;
      if (req_ch.go_left)  trn_sum = trn_sum - TGT_STEP;
      if (req_ch.go_right) trn_sum = trn_sum + TGT_STEP;
      if (trn_sum > TRN_MAX) begin
         trn_sum = TRN_MAX;
      end else if (trn_sum < -TRN_MAX) begin
         trn_sum = -TRN_MAX;
      end
   end

   // shifted views of the accumulator
   assign shift_f  = bcc_pkg::trunc_shift(acc, GAIN_FRAC_BITS);
   assign shift_f8 = bcc_pkg::trunc_shift(acc, GAIN_FRAC_BITS + 8);
   assign low      = shift_f[ERR_W-1:0];

   // integral update and clamp
   always_comb begin
      isum = ISUM_W'(integ_ff) + ISUM_W'(low);
      if (isum > INT_MAX) begin
         isum = INT_MAX;
      end else if (isum < -INT_MAX) begin
         isum = -INT_MAX;
      end
   end

   // final mix of upright/speed output with the turn term
   assign lim_m = $signed({{(MIX_W-LIMIT_W){1'b0}}, cfg.pwm_limit});
   assign lim_d = $signed({1'b0, cfg.pwm_limit});
   assign mix_l = MIX_W'(pwm_ff) - MIX_W'(turn_ff);
   assign mix_r = MIX_W'(pwm_ff) + MIX_W'(turn_ff);

   // sequencer: operand selection, accumulator control and captures
   always_comb begin
      state_in     = state_ff;
      st_in        = st_ff;
      tt_in        = tt_ff;
      fe_in        = fe_ff;
      integ_in     = integ_ff;
      pend_in      = pend_ff;
      err_in       = err_ff;
      diff_in      = diff_ff;
      gy_in        = gy_ff;
      gz_in        = gz_ff;
      kd_in        = kd_ff;
      fall_in      = fall_ff;
      vert_in      = vert_ff;
      vel_in       = vel_ff;
      turn_in      = turn_ff;
      pwm_in       = pwm_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      drive_l_in   = drive_l_ff;
      drive_r_in   = drive_r_ff;
      fallen_in    = fallen_ff;
      op_a         = '0;
      op_b         = '0;
      mac_ctl      = '{acc_load: 1'b0, acc_add: 1'b0, load_val: '0};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               st_in    = spd_sum[TARGET_W-1:0];
               tt_in    = trn_sum[TARGET_W-1:0];
               err_in   = ERR_W'(req_ch.enc_left) + ERR_W'(req_ch.enc_right)
                          - ERR_W'(spd_sum);
               diff_in  = DIFF_W'(req_ch.pitch) - DIFF_W'(cfg.balance_angle);
               gy_in    = req_ch.rate_y;
               gz_in    = req_ch.rate_z;
               kd_in    = (req_ch.go_left || req_ch.go_right) ? '0 : cfg.steer_kd;
               fall_in  = (req_ch.pitch > FALL_MAX) || (req_ch.pitch < -FALL_MAX);
               state_in = ST_FILT_NEW;
            end
         end
         ST_FILT_NEW: begin
            op_a     = $signed(FILTER_NEW);
            op_b     = MUL_W'(err_ff);
            state_in = ST_FILT_OLD;
         end
         ST_FILT_OLD: begin
            op_a     = $signed(FILTER_OLD);
            op_b     = MUL_W'(fe_ff);
            mac_ctl  = '{acc_load: 1'b1, acc_add: 1'b1, load_val: '0};
            state_in = ST_UP_ANGLE;
         end
         ST_UP_ANGLE: begin
            op_a     = $signed({1'b0, cfg.upright_kp});
            op_b     = MUL_W'(diff_ff);
            mac_ctl  = '{acc_load: 1'b0, acc_add: 1'b1, load_val: '0};
            state_in = ST_UP_RATE;
         end
         ST_UP_RATE: begin
            // filter output ready: update filter, integral and pending clear
            fe_in    = low;
            integ_in = pend_ff ? '0 : isum[INTEG_W-1:0];
            pend_in  = fall_ff;
            op_a     = $signed({1'b0, cfg.upright_kd});
            op_b     = MUL_W'(gy_ff) <<< 8;
            mac_ctl  = '{acc_load: 1'b1, acc_add: 1'b1, load_val: '0};
            state_in = ST_SPD_P;
         end
         ST_SPD_P: begin
            op_a     = $signed({1'b0, cfg.speed_kp});
            op_b     = MUL_W'(fe_ff);
            mac_ctl  = '{acc_load: 1'b0, acc_add: 1'b1, load_val: '0};
            state_in = ST_SPD_I;
         end
         ST_SPD_I: begin
            vert_in  = bcc_pkg::sat32(shift_f8);
            op_a     = $signed({1'b0, cfg.speed_ki});
            op_b     = MUL_W'(integ_ff);
            mac_ctl  = '{acc_load: 1'b1, acc_add: 1'b1, load_val: '0};
            state_in = ST_STR_D;
         end
         ST_STR_D: begin
            op_a     = $signed({1'b0, kd_ff});
            op_b     = MUL_W'(gz_ff);
            mac_ctl  = '{acc_load: 1'b0, acc_add: 1'b1, load_val: '0};
            state_in = ST_STR_P;
         end
         ST_STR_P: begin
            vel_in   = bcc_pkg::sat32(shift_f);
            op_a     = $signed({1'b0, cfg.steer_kp});
            op_b     = MUL_W'(tt_ff);
            mac_ctl  = '{acc_load: 1'b1, acc_add: 1'b1, load_val: '0};
            state_in = ST_MIX_VEL;
         end
         ST_MIX_VEL: begin
            op_a     = $signed({1'b0, cfg.upright_kp});
            op_b     = MUL_W'(vel_ff);
            mac_ctl  = '{acc_load: 1'b0, acc_add: 1'b1, load_val: '0};
            state_in = ST_MIX_VERT;
         end
         ST_MIX_VERT: begin
            turn_in  = shift_f[TURN_W-1:0];
            mac_ctl  = '{acc_load: 1'b1, acc_add: 1'b1,
                         load_val: ACC_W'(vert_ff) <<< GAIN_FRAC_BITS};
            state_in = ST_PWM;
         end
         ST_PWM: begin
            pwm_in   = bcc_pkg::sat32(shift_f);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               drive_l_in   = fall_ff ? '0 : clamp_drive(mix_l, lim_m);
               drive_r_in   = fall_ff ? '0 : clamp_drive(mix_r, lim_m);
               fallen_in    = fall_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         st_ff        <= '0;
         tt_ff        <= '0;
         fe_ff        <= '0;
         integ_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         st_ff        <= st_in;
         tt_ff        <= tt_in;
         fe_ff        <= fe_in;
         integ_ff     <= integ_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      err_ff     <= err_in;
      diff_ff    <= diff_in;
      gy_ff      <= gy_in;
      gz_ff      <= gz_in;
      kd_ff      <= kd_in;
      fall_ff    <= fall_in;
      vert_ff    <= vert_in;
      vel_ff     <= vel_in;
      turn_ff    <= turn_in;
      pwm_ff     <= pwm_in;
      drive_l_ff <= drive_l_in;
      drive_r_ff <= drive_r_in;
      fallen_ff  <= fallen_in;
   end

   // checks on the sequencer and the result
   `BCC_ASSERT_NEXT(a_busy_after_take, clock, reset, req_take, !req_ch.ready, "ready during tick")
   `BCC_ASSERT_IMPLY(a_fallen_zero, clock, reset, rsp_valid_ff && fallen_ff, (drive_l_ff == '0) && (drive_r_ff == '0), "drive while fallen")
   `BCC_ASSERT_IMPLY(a_drive_limit, clock, reset, rsp_valid_ff, (drive_l_ff <= lim_d) && (drive_l_ff >= -lim_d) && (drive_r_ff <= lim_d) && (drive_r_ff >= -lim_d), "drive beyond limit")
   `BCC_ASSERT_ALWAYS(a_integ_range, clock, reset, (integ_ff <= INTEG_W'(bcc_pkg::INTEGRAL_LIMIT)) && (integ_ff >= -INTEG_W'(bcc_pkg::INTEGRAL_LIMIT)), "integral out of range")

endmodule

[hw/rtl/bcc_csr.sv]
// configuration register bank: gains, balance angle and drive limit
// depends on bcc_pkg and bcc_csr_if
module bcc_csr (
   input  logic             clock,
   input  logic             reset,
   bcc_csr_if.sink          csr_ch,
   output bcc_pkg::cfg_type cfg
);

   bcc_pkg::cfg_type cfg_ff;
   bcc_pkg::cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   // register write decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            bcc_pkg::CSR_UPRIGHT_KP:    cfg_in.upright_kp    = csr_ch.data;
            bcc_pkg::CSR_UPRIGHT_KD:    cfg_in.upright_kd    = csr_ch.data;
            bcc_pkg::CSR_SPEED_KP:      cfg_in.speed_kp      = csr_ch.data;
            bcc_pkg::CSR_SPEED_KI:      cfg_in.speed_ki      = csr_ch.data;
            bcc_pkg::CSR_STEER_KP:      cfg_in.steer_kp      = csr_ch.data;
            bcc_pkg::CSR_STEER_KD:      cfg_in.steer_kd      = csr_ch.data;
            bcc_pkg::CSR_BALANCE_ANGLE: cfg_in.balance_angle =
                                           csr_ch.data[bcc_pkg::IN_W-1:0];
            bcc_pkg::CSR_PWM_LIMIT:     cfg_in.pwm_limit     =
                                           csr_ch.data[bcc_pkg::LIMIT_W-1:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= bcc_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hw/rtl/bcc_mac.sv]
// shared signed multiply-accumulate unit: registered product, then accumulate
// depends on bcc_pkg for widths and the control struct
module bcc_mac (
   input  logic                                  clock,
   input  logic signed [bcc_pkg::MUL_W-1:0]      op_a,
   input  logic signed [bcc_pkg::MUL_W-1:0]      op_b,
   input  bcc_pkg::mac_ctl_type                  ctl,
   output logic signed [bcc_pkg::ACC_W-1:0]      acc
);

   localparam int ACC_W = bcc_pkg::ACC_W;

   logic signed [ACC_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] prod_in;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;

   // full-width product, operands sign extended by the context
   assign prod_in = op_a * op_b;

   // accumulator: optional reload, then add of the previous product
   always_comb begin
      acc_in = ctl.acc_load ? ctl.load_val : acc_ff;
      if (ctl.acc_add) begin
         acc_in = acc_in + prod_ff;
      end
   end

   assign acc = acc_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

endmodule
